FILE: rtl/mroe_pkg.sv
package mroe_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  // Size registers hold 5 bits; writes keep the low 5 bits.
  localparam int SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SCALE = 2'd2,
    OP_SUB   = 2'd3
  } op_t;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;      // capture the accepted item's fields
    logic              wr_elem;   // write one element at (row, col)
    logic              rd_elem;   // read one element at (row, col)
    logic              issue;     // start one column of a row command
    logic [SIZE_W-1:0] col;       // column of the issued step
    logic              is_sub;    // row command subtracts into target_row
    logic              out_load;  // load the result register
    logic              take_rd;   // result carries the element read
    logic              err;       // result reports an index error
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic pipe_busy;
  } sts_t;

endpackage

FILE: rtl/mroe_if.sv
interface mroe_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         row;
  logic [3:0]         target_row;
  logic [3:0]         col;
  logic signed [31:0] value;

  modport source(output valid, op, row, target_row, col, value, input ready);
  modport sink(input valid, op, row, target_row, col, value, output ready);
endinterface

interface mroe_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               status;

  modport source(output valid, read_value, status, input ready);
  modport sink(input valid, read_value, status, output ready);
endinterface

FILE: rtl/mroe_dp.sv
module mroe_dp #(
  parameter int MAX_ROWS = mroe_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mroe_pkg::MAX_COLS_DEF
) (
  input  logic               clk,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_target_row,
  input  logic [3:0]         in_col,
  input  logic signed [31:0] in_value,
  input  mroe_pkg::cmd_t     cmd,
  output mroe_pkg::sts_t     sts,
  output logic signed [31:0] read_value,
  output logic               status
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = mroe_pkg::SIZE_W;

  function automatic logic [AW-1:0] addr_of(input logic [3:0] r, input logic [CW-1:0] c);
    addr_of = AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
  endfunction

  logic signed [31:0] mem [DEPTH];

  logic [3:0]         row_q;
  logic [3:0]         trow_q;
  logic [3:0]         col_q;
  logic signed [31:0] value_q;

  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;
  logic               s1_v;
  logic [CW-1:0]      s1_col;
  logic               s2_v;
  logic [CW-1:0]      s2_col;
  logic signed [63:0] prod;
  logic signed [31:0] tgt_d;

  logic [AW-1:0]      raddr_a;
  logic [AW-1:0]      raddr_b;
  logic [AW-1:0]      waddr;
  logic               we;
  logic signed [31:0] wdata;
  logic signed [47:0] prod_sh;
  logic signed [48:0] res_wide;
  logic signed [31:0] res_sat;

  // Capture the item's fields at accept; they hold until the next accept.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_q   <= in_row;
      trow_q  <= in_target_row;
      col_q   <= in_col;
      value_q <= in_value;
    end
  end

  always_comb begin
    raddr_a = cmd.rd_elem ? addr_of(row_q, {1'b0, col_q}) : addr_of(row_q, cmd.col);
    raddr_b = addr_of(trow_q, cmd.col);
  end

  // Truncate toward minus infinity, then subtract from the target (subtract row only) and saturate.
  always_comb begin
    prod_sh  = prod[63:16];
    if (cmd.is_sub) begin
      res_wide = 49'(tgt_d) - 49'(prod_sh);
    end else begin
      res_wide = 49'(prod_sh);
    end
    if (res_wide[48:31] == '0 || res_wide[48:31] == '1) begin
      res_sat = res_wide[31:0];
    end else if (res_wide[48]) begin
      res_sat = 32'sh8000_0000;
    end else begin
      res_sat = 32'sh7fff_ffff;
    end
  end

  always_comb begin
    we = cmd.wr_elem | s2_v;
    if (cmd.wr_elem) begin
      waddr = addr_of(row_q, {1'b0, col_q});
      wdata = value_q;
    end else begin
      waddr = addr_of(cmd.is_sub ? trow_q : row_q, s2_col);
      wdata = res_sat;
    end
  end

  // Two read ports, one write port, registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // Column pipeline: read, multiply, combine and write back.
  always_ff @(posedge clk) begin
    s1_col <= cmd.col;
    prod   <= 64'(rd_a) * 64'(value_q);
    tgt_d  <= rd_b;
    s2_col <= s1_col;
  end

  always_ff @(posedge clk) begin
    s1_v <= cmd.issue;
    s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_value <= cmd.take_rd ? rd_a : 32'sd0;
      status     <= cmd.err;
    end
  end

  assign sts.pipe_busy = s1_v | s2_v;

endmodule

FILE: rtl/mroe_ctrl.sv
module mroe_ctrl #(
  parameter int MAX_ROWS = mroe_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mroe_pkg::MAX_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_op,
  input  logic [3:0]                   in_row,
  input  logic [3:0]                   in_target_row,
  input  logic [3:0]                   in_col,
  input  logic [mroe_pkg::SIZE_W-1:0]  rows_in_use,
  input  logic [mroe_pkg::SIZE_W-1:0]  cols_in_use,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mroe_pkg::cmd_t               cmd,
  input  mroe_pkg::sts_t               sts
);

  localparam int SW = mroe_pkg::SIZE_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ELEM  = 5'b00010,
    S_ROW   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t        state;
  state_t        state_next;
  mroe_pkg::op_t op_q;
  logic          err_q;
  logic [SW-1:0] j;
  logic [SW-1:0] j_next;

  logic [SW-1:0] nr;
  logic [SW-1:0] nc;
  logic          accept;
  logic          ok;
  logic          out_free;
  mroe_pkg::op_t op_in;

  assign op_in = mroe_pkg::op_t'(in_op);

  // Clamp the sizes to the store.
  assign nr = (32'(rows_in_use) > MAX_ROWS) ? SW'(MAX_ROWS) : rows_in_use;
  assign nc = (32'(cols_in_use) > MAX_COLS) ? SW'(MAX_COLS) : cols_in_use;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  always_comb begin
    case (op_in)
      mroe_pkg::OP_WRITE,
      mroe_pkg::OP_READ:  ok = ({1'b0, in_row} < nr) && ({1'b0, in_col} < nc);
      mroe_pkg::OP_SCALE: ok = ({1'b0, in_row} < nr);
      mroe_pkg::OP_SUB:   ok = ({1'b0, in_row} < nr) && ({1'b0, in_target_row} < nr);
      default:            ok = 1'b0;
    endcase
  end

  always_comb begin
    state_next   = state;
    j_next       = j;
    cmd          = '0;
    cmd.load     = accept;
    cmd.col      = j;
    cmd.is_sub   = (op_q == mroe_pkg::OP_SUB);
    cmd.take_rd  = (op_q == mroe_pkg::OP_READ) && !err_q;
    cmd.err      = err_q;
    case (state)
      S_IDLE: begin
        j_next = '0;
        if (accept) begin
          if (!ok) begin
            state_next = S_DONE;
          end else if (op_in == mroe_pkg::OP_WRITE || op_in == mroe_pkg::OP_READ) begin
            state_next = S_ELEM;
          end else if (nc == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_ROW;
          end
        end
      end
      S_ELEM: begin
        cmd.wr_elem = (op_q == mroe_pkg::OP_WRITE);
        cmd.rd_elem = (op_q == mroe_pkg::OP_READ);
        state_next  = S_DONE;
      end
      S_ROW: begin
        cmd.issue = 1'b1;
        j_next    = j + 1'b1;
        if (j_next == nc) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Keep the element read on the port while the result register is full.
        cmd.rd_elem = (op_q == mroe_pkg::OP_READ) && !err_q;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      j         <= '0;
      out_valid <= 1'b0;
      op_q      <= mroe_pkg::OP_WRITE;
      err_q     <= 1'b0;
    end else begin
      state <= state_next;
      j     <= j_next;
      if (accept) begin
        op_q  <= op_in;
        err_q <= !ok;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.pipe_busy)
    else $error("pipeline busy while taking a new item");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second item taken before result");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (j < nc))
    else $error("column step beyond columns in use");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");
`endif

endmodule

FILE: rtl/matrix_row_operation_engine_unit.sv
// Write/read: S_ELEM accesses the store, then S_DONE loads the result. Scale or subtract row:
// S_ROW issues one column a cycle for the N columns in use via the store's two read ports, then
// S_DRAIN empties the pipeline and S_DONE loads the result. Index errors or no columns in use go
// straight to S_DONE, which waits for a free result register; new items are taken only in S_IDLE.
// Reset (rst, synchronous) idles the controller, empties the result register and sets both
// sizes to 16; the matrix store is not cleared and holds nothing defined until written.
module matrix_row_operation_engine_unit #(
  parameter int MAX_ROWS = mroe_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mroe_pkg::MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mroe_req_if.sink    req,
  mroe_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [mroe_pkg::SIZE_W-1:0] rows_in_use;
  logic [mroe_pkg::SIZE_W-1:0] cols_in_use;
  logic                        cfg_wr;
  mroe_pkg::cmd_t              cmd;
  mroe_pkg::sts_t              sts;

  // Configuration port: zero-wait, register i at byte address 4*i.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= mroe_pkg::SIZE_RESET;
      cols_in_use <= mroe_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      // Keep the low 5 bits of the written data.
      case (mroe_pkg::reg_idx_t'(paddr[2]))
        mroe_pkg::REG_ROWS: rows_in_use <= pwdata[mroe_pkg::SIZE_W-1:0];
        mroe_pkg::REG_COLS: cols_in_use <= pwdata[mroe_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mroe_pkg::reg_idx_t'(paddr[2]))
      mroe_pkg::REG_ROWS: prdata = 32'(rows_in_use);
      mroe_pkg::REG_COLS: prdata = 32'(cols_in_use);
      default:            prdata = '0;
    endcase
  end

  // Controller: range check at accept, column sequencing, result handshake.
  mroe_ctrl #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .in_op         (req.op),
    .in_row        (req.row),
    .in_target_row (req.target_row),
    .in_col        (req.col),
    .rows_in_use   (rows_in_use),
    .cols_in_use   (cols_in_use),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .cmd           (cmd),
    .sts           (sts)
  );

  // Datapath: matrix store, multiplier pipeline, saturation and result register.
  mroe_dp #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk           (clk),
    .in_row        (req.row),
    .in_target_row (req.target_row),
    .in_col        (req.col),
    .in_value      (req.value),
    .cmd           (cmd),
    .sts           (sts),
    .read_value    (rsp.read_value),
    .status        (rsp.status)
  );

endmodule
